// ===== rtl/core/etgt_pkg.sv =====
`default_nettype none

package etgt_pkg;

    // Window length and the widths that follow from it
    localparam int WINDOW    = 20;
    localparam int POS_W     = (WINDOW > 1) ? $clog2(WINDOW) : 1;
    localparam int FILL_W    = $clog2(WINDOW + 1);
    localparam int SAMPLE_W  = 32;
    localparam int DIM_W     = 12;
    localparam int THRESH_W  = 31;
    localparam int NUM_W     = 48;

    // Sum of x over the window, and the constant regression denominator
    localparam longint SUM_X = longint'(WINDOW) * (WINDOW - 1) / 2;
    localparam longint DENOM = longint'(WINDOW) * WINDOW * (longint'(WINDOW) * WINDOW - 1) / 12;

    // Running sums: y needs log2(WINDOW) growth bits, x*y needs log2(SUM_X) plus sign
    localparam int SUM_Y_W   = SAMPLE_W + $clog2(WINDOW);
    localparam int SUM_XY_W  = SAMPLE_W + $clog2(SUM_X) + 1;

    // Slope >= -0.01 in Q16.16 is 100*num >= -65536*DENOM, i.e. num >= -floor(65536*DENOM/100)
    localparam longint SLOPE_FLOOR = -((longint'(65536) * DENOM) / 100);
    localparam logic signed [NUM_W-1:0] NUM_FLOOR = NUM_W'(SLOPE_FLOOR);

    // Configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_ERR_LEVEL = 2'd0,
        REG_MAX_DIM   = 2'd1
    } cfg_reg_t;

    localparam logic [THRESH_W-1:0] ERR_LEVEL_RST = THRESH_W'(65536);
    localparam logic [DIM_W-1:0]    MAX_DIM_RST   = DIM_W'(4095);

endpackage

`default_nettype wire

// ===== rtl/core/error_trend_growth_trigger_unit.sv =====
// Error trend growth trigger. Each transfer on the s_ channel carries one signed Q16.16 error
// sample and the latent dimension in use; each produces exactly one result on the m_ channel,
// registered through one input stage and one result stage. One sample is accepted every
// cycle while s_ready is high: the last WINDOW samples sit in a small register file,
// and the running sums of y and x*y are updated in one step per sample. With m_ready low,
// two samples are held before s_ready drops. The second stage forms the least-squares slope
// numerator n*sum_xy - sum_x*sum_y and checks the trigger conditions: full window, error at
// or above the error level register, slope not below -0.01, and latent dimension below
// max_dim. Until WINDOW samples have been seen, trend_numerator and trigger read zero.
// Configuration is written through the cfg_ port (index 0: error level, index 1: max_dim;
// other indices are ignored). Only write it while the block is idle; the block does not check.
`default_nettype none

module error_trend_growth_trigger_unit
    import etgt_pkg::*;
(
    input  wire logic                         aclk,
    input  wire logic                         aresetn,

    input  wire logic                         s_valid,
    output logic                              s_ready,
    input  wire logic signed [SAMPLE_W-1:0]   s_error_sample,
    input  wire logic        [DIM_W-1:0]      s_latent_dim,

    output logic                              m_valid,
    input  wire logic                         m_ready,
    output logic                              m_trigger,
    output logic signed [NUM_W-1:0]           m_trend_numerator,
    output logic                              m_window_full,

    input  wire logic                         cfg_valid,
    output logic                              cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]         cfg_index,
    input  wire logic [CFG_DATA_W-1:0]        cfg_data
);

    // Configuration registers
    logic [THRESH_W-1:0] err_level_reg;
    logic [DIM_W-1:0]    max_dim_reg;

    // Window state
    logic signed [SAMPLE_W-1:0] samples_reg [WINDOW];
    logic [POS_W-1:0]           pos_reg, pos_next;
    logic [FILL_W-1:0]          fill_reg, fill_next;
    logic [SUM_Y_W-1:0]         sum_y_reg, sum_y_next;
    logic [SUM_XY_W-1:0]        sum_xy_reg, sum_xy_next;

    // Stage one: the accepted sample, its dimension and window status
    logic                       s1_valid_reg;
    logic signed [SAMPLE_W-1:0] s1_y_reg;
    logic [DIM_W-1:0]           s1_dim_reg;
    logic                       s1_full_reg;

    // Result register
    logic                       m_valid_reg;
    logic                       m_trigger_reg;
    logic signed [NUM_W-1:0]    m_num_reg;
    logic                       m_full_reg;

    logic                       s_accept;
    logic                       s1_advance;
    logic                       cfg_accept;
    logic signed [SAMPLE_W-1:0] y_old;
    logic [SUM_XY_W-1:0]        y_new_xy;
    logic [SUM_XY_W-1:0]        y_old_xy;
    logic [SUM_XY_W-1:0]        sum_y_xy;
    logic [NUM_W-1:0]           xy_ext;
    logic [NUM_W-1:0]           y_ext;
    logic signed [NUM_W-1:0]    num_calc;
    logic                       trig_calc;

    // Handshakes: stage one moves on when the result register is free or being emptied
    assign s1_advance = !m_valid_reg || m_ready;
    assign s_ready    = !s1_valid_reg || s1_advance;
    assign s_accept   = s_valid && s_ready;
    assign cfg_ready  = 1'b1;
    assign cfg_accept = cfg_valid && cfg_ready;

    // Oldest sample; slots not yet filled count as zero
    assign y_old = (fill_reg < FILL_W'(WINDOW)) ? '0 : samples_reg[pos_reg];

    // Running sum update: every kept sample moves down one x position, the new one lands at n-1
    always_comb begin
        y_new_xy    = SUM_XY_W'(s_error_sample);
        y_old_xy    = SUM_XY_W'(y_old);
        sum_y_xy    = SUM_XY_W'($signed(sum_y_reg));
        sum_y_next  = sum_y_reg - SUM_Y_W'(y_old) + SUM_Y_W'(s_error_sample);
        sum_xy_next = sum_xy_reg - (sum_y_xy - y_old_xy)
                    + y_new_xy * SUM_XY_W'(WINDOW - 1);
        pos_next    = (pos_reg == POS_W'(WINDOW - 1)) ? '0 : pos_reg + POS_W'(1);
        fill_next   = (fill_reg < FILL_W'(WINDOW)) ? fill_reg + FILL_W'(1) : fill_reg;
    end

    // Configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            err_level_reg <= ERR_LEVEL_RST;
            max_dim_reg   <= MAX_DIM_RST;
        end else if (cfg_accept) begin
            unique case (cfg_index)
                REG_ERR_LEVEL: err_level_reg <= cfg_data[THRESH_W-1:0];
                REG_MAX_DIM:   max_dim_reg   <= cfg_data[DIM_W-1:0];
                default: ;
            endcase
        end
    end

    // Sample store: payload only, unfilled slots are masked by the fill count
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            samples_reg[pos_reg] <= s_error_sample;
        end
    end

    // Window control state and stage one
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg      <= '0;
            fill_reg     <= '0;
            sum_y_reg    <= '0;
            sum_xy_reg   <= '0;
            s1_valid_reg <= 1'b0;
        end else begin
            if (s_accept) begin
                pos_reg    <= pos_next;
                fill_reg   <= fill_next;
                sum_y_reg  <= sum_y_next;
                sum_xy_reg <= sum_xy_next;
            end
            if (s_ready) begin
                s1_valid_reg <= s_valid;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            s1_y_reg    <= s_error_sample;
            s1_dim_reg  <= s_latent_dim;
            s1_full_reg <= (fill_next >= FILL_W'(WINDOW));
        end
    end

    // Stage two: slope numerator and trigger conditions; negative errors never reach the level
    always_comb begin
        xy_ext    = NUM_W'($signed(sum_xy_reg));
        y_ext     = NUM_W'($signed(sum_y_reg));
        num_calc  = $signed(xy_ext * NUM_W'(WINDOW) - y_ext * NUM_W'(SUM_X));
        trig_calc = s1_full_reg
                 && (s1_y_reg >= $signed({1'b0, err_level_reg}))
                 && (num_calc >= NUM_FLOOR)
                 && (s1_dim_reg < max_dim_reg);
    end

    // Result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (s1_advance) begin
            m_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (s1_advance && s1_valid_reg) begin
            m_trigger_reg <= trig_calc;
            m_num_reg     <= s1_full_reg ? num_calc : '0;
            m_full_reg    <= s1_full_reg;
        end
    end

    assign m_valid           = m_valid_reg;
    assign m_trigger         = m_trigger_reg;
    assign m_trend_numerator = m_num_reg;
    assign m_window_full     = m_full_reg;

endmodule

`default_nettype wire
